[rtl/core/mbe_pkg.sv]
// Shared types, constants and codes for the escape-time counter.
package mbe_pkg;

   // Number format and window limits
   localparam int FRAC_BITS  = 28;
   localparam int MAX_WINDOW = 4096;

   // Field widths
   localparam int Q_W        = 32;
   localparam int PIX_W      = 12;
   localparam int STEP_W     = 31;
   localparam int WH_W       = 13;
   localparam int ITER_W     = 16;
   localparam int CNT_W      = ITER_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 2 * Q_W;

   // Escape bound on |z|^2: 4.0 at the square's scale
   localparam logic [PROD_W-1:0] MAG_BOUND = PROD_W'(4) << (2 * FRAC_BITS);

   // Register reset values
   localparam logic [Q_W-1:0]    ORIGIN_RE_RST = 32'hE000_0000;  // -2.0
   localparam logic [Q_W-1:0]    ORIGIN_IM_RST = 32'hF000_0000;  // -1.0
   localparam logic [STEP_W-1:0] STEP_RE_RST   = 31'd262144;
   localparam logic [STEP_W-1:0] STEP_IM_RST   = 31'd262144;
   localparam logic [WH_W-1:0]   WIN_H_RST     = 13'd1024;
   localparam logic [ITER_W-1:0] MAX_ITER_RST  = 16'd255;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_RE = 3'd0,
      CSR_ORIGIN_IM = 3'd1,
      CSR_STEP_RE   = 3'd2,
      CSR_STEP_IM   = 3'd3,
      CSR_WIN_H     = 3'd4,
      CSR_MAX_ITER  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [Q_W-1:0]    origin_re;
      logic [Q_W-1:0]    origin_im;
      logic [STEP_W-1:0] step_re;
      logic [STEP_W-1:0] step_im;
      logic [WH_W-1:0]   window_height;
      logic [ITER_W-1:0] iter_limit;
   } cfg_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_MUL,
      ST_STEP,
      ST_FINISH
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_pixel;
      logic load_c;
      logic mul;
      logic step;
      logic load_out;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic c_ok;
      logic iter_end;
   } status_type;

endpackage

[rtl/core/mbe_csr.sv]
// Configuration register bank with write-side saturation of the window height.
module mbe_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output mbe_pkg::cfg_type                cfg
);

   mbe_pkg::cfg_type          cfg_ff;
   mbe_pkg::cfg_type          cfg_in;
   logic [mbe_pkg::WH_W-1:0]  win_h_sat;

   // Clamp the window height to the largest supported window
   always_comb begin
      win_h_sat = csr_write_data[mbe_pkg::WH_W-1:0];
      if (win_h_sat > mbe_pkg::WH_W'(mbe_pkg::MAX_WINDOW)) begin
         win_h_sat = mbe_pkg::WH_W'(mbe_pkg::MAX_WINDOW);
      end
   end

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (mbe_pkg::csr_index_type'(csr_index))
            mbe_pkg::CSR_ORIGIN_RE: cfg_in.origin_re = csr_write_data[mbe_pkg::Q_W-1:0];
            mbe_pkg::CSR_ORIGIN_IM: cfg_in.origin_im = csr_write_data[mbe_pkg::Q_W-1:0];
            mbe_pkg::CSR_STEP_RE:   cfg_in.step_re = csr_write_data[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_STEP_IM:   cfg_in.step_im = csr_write_data[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_WIN_H:     cfg_in.window_height = win_h_sat;
            mbe_pkg::CSR_MAX_ITER:  cfg_in.iter_limit =
                                       csr_write_data[mbe_pkg::ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_re      <= mbe_pkg::ORIGIN_RE_RST;
         cfg_ff.origin_im      <= mbe_pkg::ORIGIN_IM_RST;
         cfg_ff.step_re        <= mbe_pkg::STEP_RE_RST;
         cfg_ff.step_im        <= mbe_pkg::STEP_IM_RST;
         cfg_ff.window_height  <= mbe_pkg::WIN_H_RST;
         cfg_ff.iter_limit     <= mbe_pkg::MAX_ITER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/mbe_dp.sv]
// Datapath: pixel mapping, complex square with escape test, iteration counter.
module mbe_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mbe_pkg::cfg_type              cfg,
   input  mbe_pkg::cmd_type              cmd,
   input  logic [mbe_pkg::PIX_W-1:0]     pixel_col,
   input  logic [mbe_pkg::PIX_W-1:0]     pixel_row,
   output mbe_pkg::status_type           status,
   output logic [mbe_pkg::CNT_W-1:0]     iteration_count
);

   localparam int RE_PROD_W = mbe_pkg::PIX_W + mbe_pkg::STEP_W;
   localparam int ROW_OFF_W = mbe_pkg::WH_W + 1;
   localparam int MAP_W     = ROW_OFF_W + mbe_pkg::STEP_W + 1;
   localparam int P_W       = mbe_pkg::PROD_W;
   localparam int Q_W       = mbe_pkg::Q_W;

   // Mapping products
   logic [RE_PROD_W-1:0]        re_prod_ff, re_prod_in;
   logic signed [MAP_W-1:0]     im_prod_ff, im_prod_in;
   logic signed [ROW_OFF_W-1:0] row_off;
   logic [MAP_W-1:0]            re_map, im_map;

   // Point c, iterate z, products
   logic signed [Q_W-1:0]  cre_ff, cre_in, cim_ff, cim_in;
   logic signed [Q_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [P_W-1:0]  xx_ff, xx_in, yy_ff, yy_in, xy_ff, xy_in;
   logic                   pending_ff, pending_in;

   // Counter, limit, result
   logic [mbe_pkg::CNT_W-1:0] count_ff, count_in, limit_ff, limit_in, out_ff, out_in;

   // Step arithmetic
   logic signed [P_W-1:0]     diff, re_sh, im_sh, cre_ext, cim_ext, re_full, im_full;
   logic [P_W-1:0]            mag;
   logic                      mag_over, accept, cand_ok, c_ok;
   logic [mbe_pkg::CNT_W-1:0] count_next;

   function automatic logic fits_q(input logic [P_W-1:0] v);
      fits_q = (v[P_W-1:Q_W-1] == '0) || (v[P_W-1:Q_W-1] == '1);
   endfunction

   // Map the pixel: column and flipped row times step
   always_comb begin
      row_off = $signed({1'b0, cfg.window_height}) - $signed({2'b00, pixel_row});
      re_prod_in = re_prod_ff;
      im_prod_in = im_prod_ff;
      limit_in   = limit_ff;
      if (cmd.load_pixel) begin
         re_prod_in = pixel_col * cfg.step_re;
         im_prod_in = row_off * $signed({1'b0, cfg.step_im});
         limit_in   = {1'b0, cfg.iter_limit} + mbe_pkg::CNT_W'(1);
      end
   end

   // Add the origin and range-check c
   always_comb begin
      re_map = {{(MAP_W - RE_PROD_W){1'b0}}, re_prod_ff}
             + {{(MAP_W - Q_W){cfg.origin_re[Q_W-1]}}, cfg.origin_re};
      im_map = im_prod_ff
             + {{(MAP_W - Q_W){cfg.origin_im[Q_W-1]}}, cfg.origin_im};
      c_ok = ((re_map[MAP_W-1:Q_W-1] == '0) || (re_map[MAP_W-1:Q_W-1] == '1))
          && ((im_map[MAP_W-1:Q_W-1] == '0) || (im_map[MAP_W-1:Q_W-1] == '1));
   end

   // Square the iterate
   always_comb begin
      xx_in = xx_ff;
      yy_in = yy_ff;
      xy_in = xy_ff;
      if (cmd.mul) begin
         xx_in = x_ff * x_ff;
         yy_in = y_ff * y_ff;
         xy_in = x_ff * y_ff;
      end
   end

   // Test the held candidate and form the next one from the same products
   always_comb begin
      mag      = xx_ff + yy_ff;
      mag_over = mag > mbe_pkg::MAG_BOUND;
      accept   = pending_ff && !mag_over;
      count_next = accept ? count_ff + mbe_pkg::CNT_W'(1) : count_ff;
      diff    = xx_ff - yy_ff;
      re_sh   = diff >>> mbe_pkg::FRAC_BITS;
      im_sh   = xy_ff >>> (mbe_pkg::FRAC_BITS - 1);
      cre_ext = {{(P_W - Q_W){cre_ff[Q_W-1]}}, cre_ff};
      cim_ext = {{(P_W - Q_W){cim_ff[Q_W-1]}}, cim_ff};
      re_full = re_sh + cre_ext;
      im_full = im_sh + cim_ext;
      cand_ok = fits_q(re_full) && fits_q(im_full);
      status.c_ok     = c_ok;
      status.iter_end = (pending_ff && mag_over)
                     || (accept && (count_next == limit_ff))
                     || !cand_ok;
   end

   // Iterate and counter updates
   always_comb begin
      cre_in     = cre_ff;
      cim_in     = cim_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      out_in     = out_ff;
      if (cmd.load_c) begin
         cre_in     = re_map[Q_W-1:0];
         cim_in     = im_map[Q_W-1:0];
         x_in       = re_map[Q_W-1:0];
         y_in       = im_map[Q_W-1:0];
         count_in   = '0;
         pending_in = 1'b0;
      end
      if (cmd.step) begin
         x_in       = re_full[Q_W-1:0];
         y_in       = im_full[Q_W-1:0];
         count_in   = count_next;
         pending_in = 1'b1;
      end
      if (cmd.load_out) begin
         out_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      re_prod_ff <= re_prod_in;
      im_prod_ff <= im_prod_in;
      limit_ff   <= limit_in;
      cre_ff     <= cre_in;
      cim_ff     <= cim_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      xx_ff      <= xx_in;
      yy_ff      <= yy_in;
      xy_ff      <= xy_in;
      count_ff   <= count_in;
      pending_ff <= pending_in;
      out_ff     <= out_in;
   end

   assign iteration_count = out_ff;

   // The counter never reaches the limit while still stepping
   a_count_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (count_ff < limit_ff))
      else $error("iteration counter at or past limit during a step");

endmodule

[rtl/core/mbe_ctrl.sv]
// Controller state machine: sequences mapping, iteration and result hand-off.
module mbe_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  mbe_pkg::status_type  status,
   output mbe_pkg::cmd_type     cmd
);

   mbe_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbe_pkg::ST_IDLE:   if (req_valid) state_in = mbe_pkg::ST_MAP;
         mbe_pkg::ST_MAP:    state_in = status.c_ok ? mbe_pkg::ST_MUL : mbe_pkg::ST_FINISH;
         mbe_pkg::ST_MUL:    state_in = mbe_pkg::ST_STEP;
         mbe_pkg::ST_STEP:   state_in = status.iter_end ? mbe_pkg::ST_FINISH : mbe_pkg::ST_MUL;
         mbe_pkg::ST_FINISH: if (out_free) state_in = mbe_pkg::ST_IDLE;
         default:            state_in = mbe_pkg::ST_IDLE;
      endcase
   end

   // Outputs and commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mbe_pkg::ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_pixel = req_valid;
         end
         mbe_pkg::ST_MAP:    cmd.load_c = 1'b1;
         mbe_pkg::ST_MUL:    cmd.mul = 1'b1;
         mbe_pkg::ST_STEP:   cmd.step = 1'b1;
         mbe_pkg::ST_FINISH: cmd.load_out = out_free;
         default: ;
      endcase
   end

   // Hold the result valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_accept_maps: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == mbe_pkg::ST_MAP))
      else $error("accepted transaction did not start mapping");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result is still pending");

endmodule

[rtl/core/mandelbrot_escape_time_top.sv]
// Top level of the escape-time counter: register bank, controller and datapath.
//
// Each pixel transaction maps (column, row) to c in signed Q4.28 and iterates z = z*z + c
// starting from z = c, returning the number of iterates whose |z|^2 stays within 4 and
// which fit in 32 bits, capped at the iteration limit + 1. One item is in work at a time.
// Mapping is done in the MAP state after acceptance; each step passes through the MUL
// state (the three 32x32 multipliers squaring z) and then the STEP state (the add, range
// check and escape compare); the result register is loaded in the FINISH state after the
// last step, once the output register is free. A count of n needs n+2 steps when |z|^2
// ends it (the last step only tests the magnitude) and n+1 steps when the limit or an
// overflowing iterate ends it; when c itself is out of range, MAP goes straight to FINISH.
// The controller is idle again in the cycle the result turns valid, so the next
// transaction can be taken in that cycle. A finished result waits in its output register;
// a second one waits in the counter until the first is taken. Registers are to be written
// through the csr port only between transactions: the user must keep to this, as the block
// itself does not enforce it.
module mandelbrot_escape_time_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [mbe_pkg::PIX_W-1:0]       req_pixel_col,
   input  logic [mbe_pkg::PIX_W-1:0]       req_pixel_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mbe_pkg::CNT_W-1:0]       rsp_iteration_count,
   input  logic                            csr_write_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   mbe_pkg::cfg_type    cfg;
   mbe_pkg::cmd_type    cmd;
   mbe_pkg::status_type status;

   mbe_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mbe_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .pixel_col       (req_pixel_col),
      .pixel_row       (req_pixel_row),
      .status          (status),
      .iteration_count (rsp_iteration_count)
   );

endmodule
